@@ sv/bcg_pkg.sv @@
// Shared types, constants and register indexes of the button chord gesture detector.
package bcg_pkg;

   localparam int BUTTON_W   = 3;
   localparam int TIME_W     = 32;
   localparam int LONG_W     = 14;
   localparam int HOLD_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [BUTTON_W-1:0] ALL_BUTTONS = 3'h7;

   localparam logic [LONG_W-1:0] LONG_MIN_MS   = 14'd200;
   localparam logic [LONG_W-1:0] LONG_MAX_MS   = 14'd10000;
   localparam logic [LONG_W-1:0] LONG_RESET_MS = 14'd1000;
   localparam logic [HOLD_W-1:0] HOLD_RESET_MS = 16'd10000;

   // held / 250 == (held >> 1) / 125; the quotient by 125 of a 31-bit value is
   // (x * ceil(2^38 / 125)) >> 38, exact over the whole 31-bit range.
   localparam logic [TIME_W-1:0] BLINK_RECIP = 32'd2199023256;
   localparam int                BLINK_SHIFT = 38;

   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIG_HOLD = 2'd1;

   typedef struct packed {
      logic [LONG_W-1:0] long_limit_ms;
      logic [HOLD_W-1:0] config_hold_ms;
   } cfg_type;

endpackage

@@ sv/bcg_csr.sv @@
// Configuration registers of the button chord gesture detector.
module bcg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [bcg_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [bcg_pkg::CSR_DATA_W-1:0]     wr_data,
   output bcg_pkg::cfg_type                   cfg
);

   logic [bcg_pkg::LONG_W-1:0] long_ff, long_in;
   logic [bcg_pkg::HOLD_W-1:0] hold_ff, hold_in;
   logic [bcg_pkg::LONG_W-1:0] long_raw;

   always_comb begin
      long_raw = wr_data[bcg_pkg::LONG_W-1:0];
      long_in  = long_ff;
      hold_in  = hold_ff;
      if (wr_en) begin
         unique case (wr_index)
            bcg_pkg::CSR_LONG_PRESS: begin
               // clamp to the legal long-press range
               if (long_raw < bcg_pkg::LONG_MIN_MS) begin
                  long_in = bcg_pkg::LONG_MIN_MS;
               end else if (long_raw > bcg_pkg::LONG_MAX_MS) begin
                  long_in = bcg_pkg::LONG_MAX_MS;
               end else begin
                  long_in = long_raw;
               end
            end
            bcg_pkg::CSR_CONFIG_HOLD: begin
               hold_in = wr_data[bcg_pkg::HOLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff <= bcg_pkg::LONG_RESET_MS;
         hold_ff <= bcg_pkg::HOLD_RESET_MS;
      end else begin
         long_ff <= long_in;
         hold_ff <= hold_in;
      end
   end

   assign cfg.long_limit_ms  = long_ff;
   assign cfg.config_hold_ms = hold_ff;

endmodule

@@ sv/bcg_blink.sv @@
// Blink phase of the status LED: lit while (held / 250) is even.
module bcg_blink (
   input  logic [bcg_pkg::TIME_W-1:0] held,
   output logic                       blink_lit
);

   logic [2*bcg_pkg::TIME_W-2:0] prod;

   // divide by 250 as a halving followed by a reciprocal multiply by 125
   assign prod = (2*bcg_pkg::TIME_W-1)'(held[bcg_pkg::TIME_W-1:1])
               * (2*bcg_pkg::TIME_W-1)'(bcg_pkg::BLINK_RECIP);

   assign blink_lit = ~prod[bcg_pkg::BLINK_SHIFT];

endmodule

@@ sv/button_chord_gesture_detector.sv @@
// Top level of the three-button chord gesture detector.
//
// Each item on the req_ channel is one poll sample: a pressed mask of three
// active-high buttons and a millisecond timestamp. From idle, any pressed
// button starts a gesture and stores the start time; later samples OR their
// mask into the latched chord. All three buttons latched and held for
// config_hold_ms (register 1) give a config-chord result, light the LED and
// return to idle. A hold of at least the long-press time (register 0, clamped
// to 200..10000 on write) marks the gesture as long; with all three latched and
// the hold past that time the LED blinks with a 250 ms half-period. Full
// release reports the latched mask and the long flag and turns the LED off.
// Hold time is now_ms minus the start time, modulo 2^32. Every sample gives
// exactly one result item. A sample is held in an input register and
// processed combinationally into the result register, so the block takes
// one item per cycle while rsp_stall does not hold the result register; the
// path from input register to result register (32-bit subtract, 31x32
// reciprocal multiply for the blink phase, compares) sets the clock.
// Configuration writes are taken in every cycle.
module button_chord_gesture_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bcg_pkg::BUTTON_W-1:0]       req_buttons,
   input  logic [bcg_pkg::TIME_W-1:0]         req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_press_started,
   output logic                               rsp_has_event,
   output logic [bcg_pkg::BUTTON_W-1:0]       rsp_event_mask,
   output logic                               rsp_event_long,
   output logic                               rsp_config_chord,
   output logic                               rsp_led_on,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bcg_pkg::cfg_type cfg;

   // input register
   logic                          in_valid_ff;
   logic [bcg_pkg::BUTTON_W-1:0]  in_buttons_ff;
   logic [bcg_pkg::TIME_W-1:0]    in_now_ff;

   // gesture state
   logic                          active_ff, active_in;
   logic [bcg_pkg::BUTTON_W-1:0]  chord_ff, chord_in;
   logic [bcg_pkg::TIME_W-1:0]    start_ff, start_in;
   logic                          long_ff, long_in;
   logic                          led_ff, led_in;

   // result register
   logic                          rsp_valid_ff;
   logic                          started_ff, started_in;
   logic                          has_ev_ff, has_ev_in;
   logic [bcg_pkg::BUTTON_W-1:0]  ev_mask_ff, ev_mask_in;
   logic                          ev_long_ff, ev_long_in;
   logic                          cfg_chord_ff, cfg_chord_in;

   logic                          advance;
   logic                          take;
   logic                          step;
   logic [bcg_pkg::BUTTON_W-1:0]  chord_or;
   logic [bcg_pkg::TIME_W-1:0]    held;
   logic                          blink_lit;
   logic                          all_latched;

   // configuration registers are always ready
   assign csr_ready = 1'b1;

   bcg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // handshake: the result register frees whenever its item is taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   assign chord_or    = chord_ff | in_buttons_ff;
   assign held        = in_now_ff - start_ff;
   assign all_latched = (chord_or == bcg_pkg::ALL_BUTTONS);

   bcg_blink u_blink (
      .held      (held),
      .blink_lit (blink_lit)
   );

   // one sample of the gesture logic
   always_comb begin
      active_in    = active_ff;
      chord_in     = chord_ff;
      start_in     = start_ff;
      long_in      = long_ff;
      led_in       = led_ff;
      started_in   = 1'b0;
      has_ev_in    = 1'b0;
      ev_mask_in   = '0;
      ev_long_in   = 1'b0;
      cfg_chord_in = 1'b0;
      if (!active_ff) begin
         // start a gesture on any press
         if (in_buttons_ff != '0) begin
            active_in  = 1'b1;
            start_in   = in_now_ff;
            chord_in   = in_buttons_ff;
            long_in    = 1'b0;
            started_in = 1'b1;
         end
      end else begin
         chord_in = chord_or;
         if (all_latched && (held >= bcg_pkg::TIME_W'(cfg.config_hold_ms))) begin
            // config chord: light the LED and drop back to idle
            led_in       = 1'b1;
            cfg_chord_in = 1'b1;
            active_in    = 1'b0;
         end else begin
            if (held >= bcg_pkg::TIME_W'(cfg.long_limit_ms)) begin
               long_in = 1'b1;
            end
            if (all_latched && (held > bcg_pkg::TIME_W'(cfg.long_limit_ms))) begin
               led_in = blink_lit;
            end
            if (in_buttons_ff == '0) begin
               // full release: report the chord and turn the LED off
               active_in = 1'b0;
               led_in    = 1'b0;
               if (chord_or != '0) begin
                  has_ev_in  = 1'b1;
                  ev_mask_in = chord_or;
                  ev_long_in = long_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_buttons_ff <= req_buttons;
         in_now_ff     <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         chord_ff  <= '0;
         start_ff  <= '0;
         long_ff   <= 1'b0;
         led_ff    <= 1'b0;
      end else if (step) begin
         active_ff <= active_in;
         chord_ff  <= chord_in;
         start_ff  <= start_in;
         long_ff   <= long_in;
         led_ff    <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // hold the result payload while it waits to be taken
   always_ff @(posedge clock) begin
      if (step) begin
         started_ff   <= started_in;
         has_ev_ff    <= has_ev_in;
         ev_mask_ff   <= ev_mask_in;
         ev_long_ff   <= ev_long_in;
         cfg_chord_ff <= cfg_chord_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_press_started = started_ff;
   assign rsp_has_event     = has_ev_ff;
   assign rsp_event_mask    = ev_mask_ff;
   assign rsp_event_long    = ev_long_ff;
   assign rsp_config_chord  = cfg_chord_ff;
   assign rsp_led_on        = led_ff;

`ifndef NO_ASSERTIONS
   // a config chord always leaves the LED lit
   a_cfg_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_chord |-> rsp_led_on)
      else $error("config chord result with LED off");

   // a reported event carries a chord, leaves the LED off and starts nothing
   a_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_event |->
         (rsp_event_mask != '0) && !rsp_led_on && !rsp_press_started && !rsp_config_chord)
      else $error("malformed release event");

   // mask and long flag appear only with an event
   a_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_event |-> (rsp_event_mask == '0) && !rsp_event_long)
      else $error("event fields set without an event");

   // a sample starting a gesture leaves the block active
   a_start_active: assert property (@(posedge clock) disable iff (reset)
      step && started_in |=> active_ff)
      else $error("gesture start did not take effect");
`endif

endmodule

@@ tb/tb_button_chord_gesture_detector.sv @@
// Self-checking testbench for the button chord gesture detector.
module tb_button_chord_gesture_detector;
   timeunit 1ns;
   timeprecision 1ps;

   // Blink half-period of the status LED while the full chord is held long.
   localparam logic [bcg_pkg::TIME_W-1:0] BLINK_HALF_MS = 32'd250;
   // Register indexes past the end of the list; writes there must be ignored.
   localparam logic [bcg_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [bcg_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   // Generous ceiling: well above the slowest legal run with worst gaps and stalls.
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [bcg_pkg::BUTTON_W-1:0] buttons;
      logic [bcg_pkg::TIME_W-1:0]   now_ms;
   } poll_sample_type;

   typedef struct packed {
      logic                         press_started;
      logic                         has_event;
      logic [bcg_pkg::BUTTON_W-1:0] event_mask;
      logic                         event_long;
      logic                         config_chord;
      logic                         led_on;
   } gesture_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   // Every input port of the block is driven to a known level from time zero.
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [bcg_pkg::BUTTON_W-1:0]   req_buttons = '0;
   logic [bcg_pkg::TIME_W-1:0]     req_now_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_press_started;
   logic                           rsp_has_event;
   logic [bcg_pkg::BUTTON_W-1:0]   rsp_event_mask;
   logic                           rsp_event_long;
   logic                           rsp_config_chord;
   logic                           rsp_led_on;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [bcg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bcg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   button_chord_gesture_detector dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_buttons       (req_buttons),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_press_started (rsp_press_started),
      .rsp_has_event     (rsp_has_event),
      .rsp_event_mask    (rsp_event_mask),
      .rsp_event_long    (rsp_event_long),
      .rsp_config_chord  (rsp_config_chord),
      .rsp_led_on        (rsp_led_on),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // Samples waiting to be offered, and the results owed for accepted samples.
   poll_sample_type    pending_samples[$];
   gesture_result_type expected_results[$];

   // Our own copy of the configuration, updated on every completed write.
   logic [bcg_pkg::LONG_W-1:0] long_press_cfg  = bcg_pkg::LONG_RESET_MS;
   logic [bcg_pkg::HOLD_W-1:0] config_hold_cfg = bcg_pkg::HOLD_RESET_MS;

   // Our own copy of the gesture state.
   logic                         gesture_active = 1'b0;
   logic [bcg_pkg::BUTTON_W-1:0] gesture_chord  = '0;
   logic [bcg_pkg::TIME_W-1:0]   gesture_start  = '0;
   logic                         gesture_long   = 1'b0;
   logic                         led_level      = 1'b0;

   int             errors = 0;
   int             queued_items = 0;
   int             cycle_count = 0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             stall_span = 0;
   int unsigned    stall_tick = 0;
   stall_mode_type stall_mode = STALL_NONE;
   logic [bcg_pkg::TIME_W-1:0] sample_clock_ms = '0;

   poll_sample_type    next_sample;
   gesture_result_type predicted;
   gesture_result_type oldest;

   // Advance the gesture state by one poll sample and return the result it owes.
   function automatic gesture_result_type predict_gesture(input poll_sample_type s);
      gesture_result_type         r;
      logic [bcg_pkg::TIME_W-1:0] held;
      r = '0;
      if (!gesture_active) begin
         // From idle only a nonzero mask opens a gesture; an empty one changes nothing.
         if (s.buttons != '0) begin
            gesture_active = 1'b1;
            gesture_start  = s.now_ms;
            gesture_chord  = s.buttons;
            gesture_long   = 1'b0;
            r.press_started = 1'b1;
         end
      end else begin
         gesture_chord = gesture_chord | s.buttons;
         held = s.now_ms - gesture_start;   // wraps modulo 2^32
         if (gesture_chord == bcg_pkg::ALL_BUTTONS &&
             held >= bcg_pkg::TIME_W'(config_hold_cfg)) begin
            // Config chord: light the LED and drop back to idle without a release.
            led_level      = 1'b1;
            r.config_chord = 1'b1;
            gesture_active = 1'b0;
         end else begin
            if (held >= bcg_pkg::TIME_W'(long_press_cfg)) gesture_long = 1'b1;
            // Blink only strictly past the long-press time.
            if (gesture_chord == bcg_pkg::ALL_BUTTONS &&
                held > bcg_pkg::TIME_W'(long_press_cfg))
               led_level = ((held / BLINK_HALF_MS) % 2) == 0;
            if (s.buttons == '0) begin
               gesture_active = 1'b0;
               led_level      = 1'b0;
               if (gesture_chord != '0) begin
                  r.has_event  = 1'b1;
                  r.event_mask = gesture_chord;
                  r.event_long = gesture_long;
               end
            end
         end
      end
      r.led_on = led_level;
      return r;
   endfunction

   task automatic queue_sample(input logic [bcg_pkg::BUTTON_W-1:0] b,
                               input logic [bcg_pkg::TIME_W-1:0] t);
      poll_sample_type s;
      s.buttons = b;
      s.now_ms  = t;
      pending_samples.push_back(s);
      queued_items++;
   endtask

   // Pick the next timestamp of a gesture: small, medium or large steps, or land
   // within a couple of ms of the long-press or config-hold boundary.
   function automatic logic [bcg_pkg::TIME_W-1:0] next_time(
         input logic [bcg_pkg::TIME_W-1:0] start,
         input logic [bcg_pkg::TIME_W-1:0] last);
      logic [bcg_pkg::TIME_W-1:0] t;
      case ($urandom_range(0, 4))
         0: t = last + $urandom_range(0, 20);
         1: t = last + $urandom_range(20, 400);
         2: t = last + $urandom_range(400, 3000);
         3: t = start + bcg_pkg::TIME_W'(long_press_cfg) + $urandom_range(0, 4) - 2;
         default: t = start + bcg_pkg::TIME_W'(config_hold_cfg) + $urandom_range(0, 4) - 2;
      endcase
      return t;
   endfunction

   // Queue one well-formed gesture with random content; optionally leave it open.
   task automatic queue_gesture(input bit with_release);
      logic [bcg_pkg::TIME_W-1:0]   start;
      logic [bcg_pkg::TIME_W-1:0]   t_ms;
      logic [bcg_pkg::BUTTON_W-1:0] mask;
      int                           holds;
      start = sample_clock_ms;
      t_ms  = start;
      queue_sample(bcg_pkg::BUTTON_W'($urandom_range(1, 7)), t_ms);
      holds = $urandom_range(0, 7);
      for (int i = 0; i < holds; i++) begin
         t_ms = next_time(start, t_ms);
         // Favour the full chord so the blink and config paths get plenty of use.
         mask = ($urandom_range(0, 3) == 0) ? bcg_pkg::ALL_BUTTONS
                                            : bcg_pkg::BUTTON_W'($urandom_range(1, 7));
         queue_sample(mask, t_ms);
      end
      if (with_release) begin
         t_ms = next_time(start, t_ms);
         queue_sample('0, t_ms);
      end
      sample_clock_ms = t_ms + $urandom_range(1, 800);
   endtask

   // Mostly gestures, the rest open gestures, noise samples and time jumps.
   task automatic queue_random(input int count);
      int goal;
      int pick;
      goal = queued_items + count;
      while (queued_items < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            queue_gesture(1'b1);
         end else if (pick < 80) begin
            queue_gesture(1'b0);
         end else if (pick < 92) begin
            queue_sample(bcg_pkg::BUTTON_W'($urandom_range(0, 7)), $urandom);
         end else begin
            sample_clock_ms = $urandom;
            queue_sample('0, sample_clock_ms);
         end
      end
   endtask

   // Hold until every queued sample is accepted and every result has arrived.
   task automatic drain_block();
      @(posedge clock);
      while (pending_samples.size() != 0 || expected_results.size() != 0 || req_valid)
         @(posedge clock);
      // Let the pipeline settle before touching the registers.
      repeat (4) @(posedge clock);
   endtask

   // Write one register and track it in our copy of the configuration.
   task automatic write_csr(input logic [bcg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bcg_pkg::CSR_DATA_W-1:0] data);
      logic [bcg_pkg::LONG_W-1:0] v;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == bcg_pkg::CSR_LONG_PRESS) begin
         v = data[bcg_pkg::LONG_W-1:0];
         if (v < bcg_pkg::LONG_MIN_MS) v = bcg_pkg::LONG_MIN_MS;
         else if (v > bcg_pkg::LONG_MAX_MS) v = bcg_pkg::LONG_MAX_MS;
         long_press_cfg = v;
      end else if (idx == bcg_pkg::CSR_CONFIG_HOLD) begin
         config_hold_cfg = data;
      end
      // Idle with valid low so back-to-back writes never drive valid twice in one step.
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [bcg_pkg::BUTTON_W-1:0] want,
                              input logic [bcg_pkg::BUTTON_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // Sender: offer queued samples in bursts of random length with random gaps.
   // A stalled item is held unchanged; valid is never lowered on stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            next_sample.buttons = req_buttons;
            next_sample.now_ms  = req_now_ms;
            predicted = predict_gesture(next_sample);
            expected_results.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               next_sample = pending_samples.pop_front();
               req_valid   <= 1'b1;
               req_buttons <= next_sample.buttons;
               req_now_ms  <= next_sample.now_ms;
               burst_left--;
               if (burst_left <= 0) begin
                  // Close the burst; one in four bursts runs straight into the next.
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted result against the oldest prediction and stall
   // on a pattern of its own that changes mode at the end of each randomly sized span.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no sample outstanding, expected none, actual %0h",
                        $realtime, {rsp_press_started, rsp_has_event, rsp_event_mask,
                                    rsp_event_long, rsp_config_chord, rsp_led_on});
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("press_started", bcg_pkg::BUTTON_W'(oldest.press_started),
                           bcg_pkg::BUTTON_W'(rsp_press_started));
               check_field("has_event", bcg_pkg::BUTTON_W'(oldest.has_event),
                           bcg_pkg::BUTTON_W'(rsp_has_event));
               check_field("event_mask", oldest.event_mask, rsp_event_mask);
               check_field("event_long", bcg_pkg::BUTTON_W'(oldest.event_long),
                           bcg_pkg::BUTTON_W'(rsp_event_long));
               check_field("config_chord", bcg_pkg::BUTTON_W'(oldest.config_chord),
                           bcg_pkg::BUTTON_W'(rsp_config_chord));
               check_field("led_on", bcg_pkg::BUTTON_W'(oldest.led_on),
                           bcg_pkg::BUTTON_W'(rsp_led_on));
            end
         end
         if (stall_span == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(30, 300);
         end else begin
            stall_span--;
         end
         stall_tick++;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: rsp_stall <= (stall_tick % 5) < 2;
            default:        rsp_stall <= (stall_tick % 29) >= 22;
         endcase
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_button_chord_gesture_detector: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: long press 1000 ms, config hold 10000 ms.
      queue_sample(3'b000, 32'd0);                    // idle, nothing pressed
      queue_sample(3'b111, 32'hFFFF_FFFF);            // all three at the top of time
      queue_sample(3'b000, 32'h0000_0009);            // release across the wrap
      queue_sample(3'b001, 32'd100);                  // build the chord A, B, C
      queue_sample(3'b010, 32'd150);
      queue_sample(3'b100, 32'd1100);                 // exactly long, no blink yet
      queue_sample(3'b000, 32'd1101);                 // long event with full chord
      queue_sample(3'b010, 32'hFFFF_FF00);            // start just short of the wrap
      queue_sample(3'b101, 32'hFFFF_FF00 + 32'd1300); // full chord, blink dark phase
      queue_sample(3'b111, 32'hFFFF_FF00 + 32'd1600); // blink lit phase
      queue_sample(3'b111, 32'hFFFF_FF00 + 32'd10000);// config chord fires
      queue_sample(3'b111, 32'hFFFF_FF00 + 32'd10001);// still held: new gesture
      queue_sample(3'b000, 32'hFFFF_FF00 + 32'd10002);// short release, LED off
      queue_sample(3'b011, 32'd5000);                 // just under long
      queue_sample(3'b000, 32'd5999);
      queue_sample(3'b100, 32'd6000);                 // long reached on the release
      queue_sample(3'b100, 32'd6999);
      queue_sample(3'b000, 32'd7000);
      queue_sample(3'b000, 32'd7000);
      queue_sample(3'b111, 32'd20000);                // config hold boundary
      queue_sample(3'b111, 32'd29999);
      queue_sample(3'b111, 32'd30000);
      sample_clock_ms = 32'd40000;
      queue_random(300);
      drain_block();

      // Long press clamped from above, zero config hold.
      write_csr(bcg_pkg::CSR_LONG_PRESS, 16'hFFFF);
      write_csr(bcg_pkg::CSR_CONFIG_HOLD, 16'h0000);
      queue_sample(3'b111, 32'd100);                  // start with all three
      queue_sample(3'b111, 32'd100);                  // fires at zero hold
      queue_sample(3'b001, 32'd200);
      queue_sample(3'b110, 32'd200);                  // chord completes and fires
      queue_sample(3'b010, 32'd300);
      queue_sample(3'b000, 32'd300);
      sample_clock_ms = $urandom;
      queue_random(250);
      drain_block();

      // Long press clamped from below (upper bits dropped first), maximum hold.
      write_csr(bcg_pkg::CSR_LONG_PRESS, 16'hC064);
      write_csr(bcg_pkg::CSR_CONFIG_HOLD, 16'hFFFF);
      queue_random(250);
      drain_block();

      // Writes past the register list, then random in-range settings.
      write_csr(CSR_SPARE_2, bcg_pkg::CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_3, bcg_pkg::CSR_DATA_W'($urandom));
      write_csr(bcg_pkg::CSR_LONG_PRESS, bcg_pkg::CSR_DATA_W'($urandom_range(200, 10000)));
      write_csr(bcg_pkg::CSR_CONFIG_HOLD, bcg_pkg::CSR_DATA_W'($urandom_range(0, 3000)));
      queue_random(250);
      drain_block();

      // Long press at its ceiling, short config hold.
      write_csr(bcg_pkg::CSR_LONG_PRESS, 16'd10000);
      write_csr(bcg_pkg::CSR_CONFIG_HOLD, 16'd500);
      queue_random(250);
      drain_block();

      repeat (6) @(posedge clock);
      if (errors == 0) begin
         $display("tb_button_chord_gesture_detector: done, clean");
      end else begin
         $display("tb_button_chord_gesture_detector: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/bcg_pkg.sv
sv/bcg_csr.sv
sv/bcg_blink.sv
sv/button_chord_gesture_detector.sv
tb/tb_button_chord_gesture_detector.sv
